// File: rtl/sdmd_pkg.sv
// ----------------------------------------------------------------------------
// sdmd_pkg
// Shared widths, register indexes and pipeline stage types of the
// sigma-delta motion detector.
// ----------------------------------------------------------------------------
package sdmd_pkg;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 17;
  localparam int AMP_W  = 4;
  localparam int PROD_W = PIX_W + AMP_W;
  localparam int MEM_W  = 2 * PIX_W;

  // Configuration register indexes (word address).
  localparam logic [1:0] REG_VAR_MIN = 2'd0;
  localparam logic [1:0] REG_VAR_MAX = 2'd1;
  localparam logic [1:0] REG_AMP     = 2'd2;

  // Stage 1: item as accepted, state read in flight.
  typedef struct packed {
    logic             first;
    logic             in_range;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
  } s1_t;

  // Stage 2: background updated, difference known.
  typedef struct packed {
    logic             act;
    logic             first;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] diff;
    logic [PIX_W-1:0] var_cand;
    logic             fwd1;
    logic             fwd3;
  } s2_t;

  // Stage 3: variance target known.
  typedef struct packed {
    logic              act;
    logic              first;
    logic [IDX_W-1:0]  idx;
    logic [PIX_W-1:0]  bg;
    logic [PIX_W-1:0]  diff;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  var_cand;
    logic              fwd1;
  } s3_t;

  // Background tap of an item that has not yet been written back.
  typedef struct packed {
    logic             act;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] bg;
  } tap_t;

  // State write of one item.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] bg;
    logic [PIX_W-1:0] variance;
  } wb_t;

endpackage

// File: rtl/sdmd_ram.sv
// ----------------------------------------------------------------------------
// sdmd_ram
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module sdmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/sdmd_bg_unit.sv
// ----------------------------------------------------------------------------
// sdmd_bg_unit
// Stage 1 to stage 2: resolves the stored state against items still in
// flight, moves the background one step toward the pixel (first frame: the
// pixel itself) and forms the absolute difference.
// ----------------------------------------------------------------------------
module sdmd_bg_unit import sdmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             s1_valid,
  input  s1_t              s1,
  input  logic [MEM_W-1:0] ram_data,
  input  tap_t             s3_tap,
  input  wb_t              wb,
  output logic             s2_valid,
  output s2_t              s2
);

  logic             s2_valid_r;
  s2_t              s2_r;
  s2_t              s2_nxt;
  logic             hit2;
  logic             hit3;
  logic             hitwb;
  logic [PIX_W-1:0] bg_old;
  logic [PIX_W-1:0] bg_new;

  // Match against the three older items whose writes the read missed.
  assign hit2  = s2_valid_r && s2_r.act && (s2_r.idx == s1.idx);
  assign hit3  = s3_tap.act && (s3_tap.idx == s1.idx);
  assign hitwb = wb.en && (wb.idx == s1.idx);

  // Newest background wins.
  always_comb begin
    if (hit2) begin
      bg_old = s2_r.bg;
    end else if (hit3) begin
      bg_old = s3_tap.bg;
    end else if (hitwb) begin
      bg_old = wb.bg;
    end else begin
      bg_old = ram_data[MEM_W-1:PIX_W];
    end
  end

  // One step toward the pixel, then the difference.
  always_comb begin
    if (s1.first) begin
      bg_new = s1.pix;
    end else if (bg_old < s1.pix) begin
      bg_new = bg_old + 8'd1;
    end else if (bg_old > s1.pix) begin
      bg_new = bg_old - 8'd1;
    end else begin
      bg_new = bg_old;
    end

    s2_nxt.act      = s1.in_range;
    s2_nxt.first    = s1.first;
    s2_nxt.idx      = s1.idx;
    s2_nxt.bg       = bg_new;
    s2_nxt.diff     = (bg_new > s1.pix) ? (bg_new - s1.pix) : (s1.pix - bg_new);
    s2_nxt.var_cand = hitwb ? wb.variance : ram_data[PIX_W-1:0];
    // The variance of a newer match is picked up later in the pipeline.
    s2_nxt.fwd1     = hit2;
    s2_nxt.fwd3     = !hit2 && hit3;
  end

  // Stage 2 register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

// File: rtl/sdmd_var_unit.sv
// ----------------------------------------------------------------------------
// sdmd_var_unit
// Stages 2 to 4: multiplies the difference by the amplification, steps and
// clamps the variance, decides motion, writes the state back and holds the
// result register.
// ----------------------------------------------------------------------------
module sdmd_var_unit import sdmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             s2_valid,
  input  s2_t              s2,
  input  logic [PIX_W-1:0] var_min,
  input  logic [PIX_W-1:0] var_max,
  input  logic [AMP_W-1:0] amp,
  output tap_t             s3_tap,
  output wb_t              wb,
  output wb_t              wr,
  output logic             out_valid,
  output logic             out_motion,
  output logic [PIX_W-1:0] out_diff
);

  logic             s3_valid_r;
  s3_t              s3_r;
  s3_t              s3_nxt;
  wb_t              wb_r;
  logic             out_valid_r;
  logic             out_motion_r;
  logic [PIX_W-1:0] out_diff_r;
  logic [PIX_W-1:0] var_old;
  logic [PIX_W-1:0] var_step;
  logic [PIX_W-1:0] var_hi;
  logic [PIX_W-1:0] var_new;

  // Stage 2 to 3: target product; an item two ahead is now in write-back.
  always_comb begin
    s3_nxt.act      = s2.act;
    s3_nxt.first    = s2.first;
    s3_nxt.idx      = s2.idx;
    s3_nxt.bg       = s2.bg;
    s3_nxt.diff     = s2.diff;
    s3_nxt.prod     = PROD_W'(amp) * PROD_W'(s2.diff);
    s3_nxt.var_cand = s2.fwd3 ? wb_r.variance : s2.var_cand;
    s3_nxt.fwd1     = s2.fwd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // Stage 3: variance step with saturation, then upper and lower clamp; a first-frame item takes var_min.
  always_comb begin
    var_old = s3_r.fwd1 ? wb_r.variance : s3_r.var_cand;
    if (PROD_W'(var_old) < s3_r.prod) begin
      var_step = (var_old == 8'hFF) ? var_old : var_old + 8'd1;
    end else if (PROD_W'(var_old) > s3_r.prod) begin
      var_step = var_old - 8'd1;
    end else begin
      var_step = var_old;
    end
    var_hi  = (var_step > var_max) ? var_max : var_step;
    var_new = s3_r.first ? var_min : ((var_hi < var_min) ? var_min : var_hi);
  end

  // State write of the item leaving stage 3.
  assign wr.en       = adv && s3_valid_r && s3_r.act;
  assign wr.idx      = s3_r.idx;
  assign wr.bg       = s3_r.bg;
  assign wr.variance = var_new;

  // Write-back copy and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r.en     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      wb_r.en     <= s3_valid_r && s3_r.act;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb_r.idx      <= s3_r.idx;
      wb_r.bg       <= s3_r.bg;
      wb_r.variance <= var_new;
      out_motion_r  <= s3_r.act && (s3_r.diff < var_new);
      out_diff_r    <= s3_r.act ? s3_r.diff : '0;
    end
  end

  assign s3_tap.act = s3_valid_r && s3_r.act;
  assign s3_tap.idx = s3_r.idx;
  assign s3_tap.bg  = s3_r.bg;
  assign wb         = wb_r;
  assign out_valid  = out_valid_r;
  assign out_motion = out_motion_r;
  assign out_diff   = out_diff_r;

`ifndef SYNTHESIS
  // An out-of-range pixel yields an all-zero result.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s3_valid_r && !s3_r.act |=> !out_motion_r && (out_diff_r == '0))
    else $error("out-of-range item gave a nonzero result");

  // A first-frame pixel has no difference and moves only with a nonzero floor.
  a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s3_valid_r && s3_r.act && s3_r.first |=>
      (out_diff_r == '0) && (out_motion_r == (var_min != '0)))
    else $error("first-frame result wrong");

  // With ordered clamps, the stored variance stays inside them.
  a_var_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en && (var_min <= var_max) |->
      (wr.variance >= var_min) && (wr.variance <= var_max))
    else $error("variance written outside its clamps");
`endif

endmodule

// File: rtl/sigma_delta_motion_detect.sv
// ----------------------------------------------------------------------------
// sigma_delta_motion_detect
// Per-pixel sigma-delta background subtraction with an APB register port.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and gives one result per pixel, in
// order, after the stage 1, 2, 3 and result registers; with the output taken
// every cycle it sustains one item per clock. A stall on the output freezes
// the whole pipeline. The background and variance of every pixel live in one
// PIXELS-entry, 16-bit RAM with one read and one write port; the read is
// issued as a pixel is accepted and the write happens as it leaves the last
// compute stage, and the results of the three items in between are forwarded,
// so repeated indexes at full rate are handled. The state is not cleared at
// reset: the first frame must be sent with first_frame set before any later
// frame uses an index. A pixel index of PIXELS or more leaves the state alone
// and yields motion 0 and difference 0.
// ----------------------------------------------------------------------------
module sigma_delta_motion_detect import sdmd_pkg::*; #(
  parameter int PIXELS = 131072
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [7:0] pixel_value, [24:8] pixel_index, rest zero
  input  logic        in_tuser,   // [0] first_frame
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] motion, [8:1] difference, rest zero
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  logic             adv;
  logic             s1_valid_r;
  s1_t              s1_r;
  s1_t              s1_nxt;
  logic [31:0]      in_idx_ext;
  logic [31:0]      wr_idx_ext;
  logic [MEM_W-1:0] ram_data;
  logic             s2_valid;
  s2_t              s2;
  tap_t             s3_tap;
  wb_t              wb;
  wb_t              wr;
  logic             out_motion;
  logic [PIX_W-1:0] out_diff;
  logic [PIX_W-1:0] var_min_r;
  logic [PIX_W-1:0] var_max_r;
  logic [AMP_W-1:0] amp_r;
  logic             cfg_wr;

  // The pipeline moves whenever the result register is free or being taken.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage 1 capture.
  assign in_idx_ext      = 32'(in_tdata[PIX_W +: IDX_W]);
  assign s1_nxt.first    = in_tuser;
  assign s1_nxt.in_range = in_idx_ext < 32'(PIXELS);
  assign s1_nxt.idx      = in_tdata[PIX_W +: IDX_W];
  assign s1_nxt.pix      = in_tdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // Per-pixel state: background in the high byte, variance in the low byte.
  assign wr_idx_ext = 32'(wr.idx);

  sdmd_ram #(
    .WIDTH(MEM_W),
    .DEPTH(PIXELS)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (wr.en),
    .wr_addr(wr_idx_ext[AW-1:0]),
    .wr_data({wr.bg, wr.variance}),
    .rd_en  (adv),
    .rd_addr(in_idx_ext[AW-1:0]),
    .rd_data(ram_data)
  );

  sdmd_bg_unit u_bg_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_valid(s1_valid_r),
    .s1      (s1_r),
    .ram_data(ram_data),
    .s3_tap  (s3_tap),
    .wb      (wb),
    .s2_valid(s2_valid),
    .s2      (s2)
  );

  sdmd_var_unit u_var_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .var_min   (var_min_r),
    .var_max   (var_max_r),
    .amp       (amp_r),
    .s3_tap    (s3_tap),
    .wb        (wb),
    .wr        (wr),
    .out_valid (out_tvalid),
    .out_motion(out_motion),
    .out_diff  (out_diff)
  );

  assign out_tdata = {7'd0, out_diff, out_motion};

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_min_r <= 8'd1;
      var_max_r <= 8'd254;
      amp_r     <= 4'd4;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_VAR_MIN: var_min_r <= cfg_pwdata[PIX_W-1:0];
        REG_VAR_MAX: var_max_r <= cfg_pwdata[PIX_W-1:0];
        REG_AMP:     amp_r     <= cfg_pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_VAR_MIN: cfg_prdata = 32'(var_min_r);
      REG_VAR_MAX: cfg_prdata = 32'(var_max_r);
      REG_AMP:     cfg_prdata = 32'(amp_r);
      default:     cfg_prdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  // A stalled pipeline keeps the item waiting in stage 1.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("stage 1 item lost during a stall");
`endif

endmodule
